FILE: sv/oaids_pkg.sv
// Shared types and constants for the ordered array store.
// Used by the controller, the datapath and the top level; no dependencies.
package oaids_pkg;

    // Parameter defaults
    localparam int CAPACITY_DEF  = 32;
    localparam int DATA_BITS_DEF = 32;

    // Port field widths
    localparam int CMD_W  = 2;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TEST,
        S_LOAD,
        S_STEP,
        S_PUT,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;     // capture the request fields
        logic check;     // judge the request, load pointer, clear results
        logic mem_rd;    // issue a memory read for the current element
        logic step;      // consume read data, move the pointer (not on a read)
        logic put;       // write the inserted value, grow the count
        logic cnt_dec;   // shrink the count after a delete
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd;       // latched request command
        logic err;       // request refused
        logic more;      // another element left to process
    } t_dp_stat;

endpackage

FILE: sv/oaids_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module oaids_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/oaids_ctrl.sv
// Sequencer for the ordered array store: handshakes and per-element stepping.
// Depends on oaids_pkg.
module oaids_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  oaids_pkg::t_dp_stat i_stat,
    output oaids_pkg::t_dp_cmd  o_cmd
);

    oaids_pkg::t_state r_state;
    oaids_pkg::t_state n_state;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oaids_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = oaids_pkg::S_CHECK;
                end
            end
            oaids_pkg::S_CHECK: begin
                n_state = i_stat.err ? oaids_pkg::S_DONE : oaids_pkg::S_TEST;
            end
            oaids_pkg::S_TEST: begin
                if (i_stat.more) begin
                    n_state = oaids_pkg::S_LOAD;
                end else if (i_stat.cmd == oaids_pkg::CMD_INSERT) begin
                    n_state = oaids_pkg::S_PUT;
                end else begin
                    n_state = oaids_pkg::S_DONE;
                end
            end
            oaids_pkg::S_LOAD: begin
                n_state = oaids_pkg::S_STEP;
            end
            oaids_pkg::S_STEP: begin
                n_state = (i_stat.cmd == oaids_pkg::CMD_READ) ? oaids_pkg::S_DONE
                                                               : oaids_pkg::S_TEST;
            end
            oaids_pkg::S_PUT: begin
                n_state = oaids_pkg::S_DONE;
            end
            oaids_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = oaids_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = oaids_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.latch    = (r_state == oaids_pkg::S_IDLE) && i_in_valid;
        o_cmd.check    = (r_state == oaids_pkg::S_CHECK);
        o_cmd.mem_rd   = (r_state == oaids_pkg::S_LOAD);
        o_cmd.step     = (r_state == oaids_pkg::S_STEP);
        o_cmd.put      = (r_state == oaids_pkg::S_PUT);
        o_cmd.cnt_dec  = (r_state == oaids_pkg::S_TEST) && !i_stat.more &&
                         (i_stat.cmd == oaids_pkg::CMD_DELETE);
        o_cmd.out_load = (r_state == oaids_pkg::S_DONE) && w_out_free;
    end

    // Output valid: set on load, drop when taken
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oaids_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == oaids_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    // A result never overwrites one still waiting
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    // An accepted request is judged on the next cycle
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == oaids_pkg::S_CHECK))
        else $error("accepted request not checked");

endmodule

FILE: sv/oaids_dp.sv
// Datapath of the ordered array store: entry memory, count, pointer, results.
// Depends on oaids_pkg and oaids_ram.
module oaids_dp #(
    parameter int CAPACITY  = oaids_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = oaids_pkg::DATA_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [oaids_pkg::CMD_W-1:0]   i_command,
    input  logic [oaids_pkg::POS_W-1:0]   i_position,
    input  logic [oaids_pkg::VAL_W-1:0]   i_value,
    input  oaids_pkg::t_dp_cmd            i_cmd,
    output oaids_pkg::t_dp_stat           o_stat,
    output logic [oaids_pkg::STAT_W-1:0]  o_status,
    output logic                          o_found,
    output logic [oaids_pkg::IDX_W-1:0]   o_index,
    output logic [oaids_pkg::VAL_W-1:0]   o_data_out,
    output logic [oaids_pkg::CNT_W-1:0]   o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = ((CW > oaids_pkg::POS_W) ? CW : oaids_pkg::POS_W) + 1;

    // Request and working state
    oaids_pkg::t_cmd                r_cmd;
    logic [oaids_pkg::POS_W-1:0]    r_pos;
    logic [oaids_pkg::VAL_W-1:0]    r_val;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_ptr;
    oaids_pkg::t_status             r_status;
    logic                           r_found;
    logic [AW-1:0]                  r_idx;
    logic [DATA_BITS-1:0]           r_data;

    // Output register
    oaids_pkg::t_status             r_o_status;
    logic                           r_o_found;
    logic [AW-1:0]                  r_o_idx;
    logic [DATA_BITS-1:0]           r_o_data;
    logic [CW-1:0]                  r_o_count;

    logic [EW-1:0]                  w_pos_e;
    logic [EW-1:0]                  w_cnt_e;
    logic [EW-1:0]                  w_ptr_e;
    logic                           w_full;
    logic                           w_empty;
    oaids_pkg::t_status             w_err_code;
    logic                           w_more;
    logic [DATA_BITS-1:0]           w_val_d;
    logic [CW-1:0]                  w_rd_ptr;
    logic                           w_wr_en;
    logic [AW-1:0]                  w_wr_addr;
    logic [DATA_BITS-1:0]           w_wr_data;
    logic [DATA_BITS-1:0]           w_rd_data;

    assign w_pos_e = EW'(r_pos);
    assign w_cnt_e = EW'(r_count);
    assign w_ptr_e = EW'(r_ptr);
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_val_d = DATA_BITS'(r_val);

    // Judge the request against the current fill
    always_comb begin
        unique case (r_cmd)
            oaids_pkg::CMD_INSERT: begin
                if (w_full) begin
                    w_err_code = oaids_pkg::ST_FULL;
                end else if (w_pos_e > w_cnt_e) begin
                    w_err_code = oaids_pkg::ST_RANGE;
                end else begin
                    w_err_code = oaids_pkg::ST_OK;
                end
            end
            oaids_pkg::CMD_SEARCH: begin
                w_err_code = w_empty ? oaids_pkg::ST_EMPTY : oaids_pkg::ST_OK;
            end
            default: begin
                if (w_empty) begin
                    w_err_code = oaids_pkg::ST_EMPTY;
                end else if (w_pos_e >= w_cnt_e) begin
                    w_err_code = oaids_pkg::ST_RANGE;
                end else begin
                    w_err_code = oaids_pkg::ST_OK;
                end
            end
        endcase
    end

    // Loop condition and read address per command
    always_comb begin
        unique case (r_cmd)
            oaids_pkg::CMD_INSERT: begin
                w_more   = (w_ptr_e > w_pos_e);
                w_rd_ptr = CW'(r_ptr - 1'b1);
            end
            oaids_pkg::CMD_DELETE: begin
                w_more   = ((w_ptr_e + 1'b1) < w_cnt_e);
                w_rd_ptr = CW'(r_ptr + 1'b1);
            end
            oaids_pkg::CMD_SEARCH: begin
                w_more   = (w_ptr_e < w_cnt_e);
                w_rd_ptr = r_ptr;
            end
            default: begin
                w_more   = 1'b1;
                w_rd_ptr = r_ptr;
            end
        endcase
    end

    assign o_stat.cmd  = r_cmd;
    assign o_stat.err  = (w_err_code != oaids_pkg::ST_OK);
    assign o_stat.more = w_more;

    // Shift moves write the element just read; insert ends with the new value
    assign w_wr_en   = i_cmd.put || (i_cmd.step &&
                       (r_cmd == oaids_pkg::CMD_INSERT || r_cmd == oaids_pkg::CMD_DELETE));
    assign w_wr_addr = i_cmd.put ? AW'(r_pos) : r_ptr[AW-1:0];
    assign w_wr_data = i_cmd.put ? w_val_d : w_rd_data;

    oaids_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.mem_rd),
        .i_rd_addr (w_rd_ptr[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= oaids_pkg::t_cmd'(i_command);
            r_pos <= i_position;
            r_val <= i_value;
        end
    end

    // Pointer and working results
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_status <= w_err_code;
            r_found  <= 1'b0;
            r_idx    <= '0;
            r_data   <= '0;
            unique case (r_cmd)
                oaids_pkg::CMD_INSERT: r_ptr <= r_count;
                oaids_pkg::CMD_SEARCH: r_ptr <= '0;
                default:               r_ptr <= CW'(r_pos);
            endcase
        end else if (i_cmd.step) begin
            unique case (r_cmd)
                oaids_pkg::CMD_INSERT: begin
                    r_ptr <= CW'(r_ptr - 1'b1);
                end
                oaids_pkg::CMD_DELETE: begin
                    r_ptr <= CW'(r_ptr + 1'b1);
                end
                oaids_pkg::CMD_SEARCH: begin
                    r_ptr <= CW'(r_ptr + 1'b1);
                    if (w_rd_data == w_val_d) begin
                        r_found <= 1'b1;
                        r_idx   <= r_ptr[AW-1:0];
                    end
                end
                default: begin
                    r_data <= w_rd_data;
                end
            endcase
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.put) begin
            r_count <= CW'(r_count + 1'b1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= CW'(r_count - 1'b1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_idx    <= r_idx;
            r_o_data   <= r_data;
            r_o_count  <= r_count;
        end
    end

    assign o_status   = r_o_status;
    assign o_found    = r_o_found;
    assign o_index    = oaids_pkg::IDX_W'(r_o_idx);
    assign o_data_out = oaids_pkg::VAL_W'(r_o_data);
    assign o_count    = oaids_pkg::CNT_W'(r_o_count);

    // Count stays within the store
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    // The final insert write only happens with room left
    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> !w_full)
        else $error("insert write into a full store");

    // Delete shrinks the count by exactly one
    a_dec_by_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |=> (r_count == CW'($past(r_count) - 1'b1)))
        else $error("delete did not shrink the count by one");

endmodule

FILE: sv/ordered_array_insert_delete_search.sv
// Top level of the ordered array store: controller plus datapath.
// Depends on oaids_pkg, oaids_ctrl, oaids_dp and oaids_ram.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries command, position and
//   value. Result channel (o_out_valid / i_out_ready) returns one result per
//   request: status, found, index, data_out and the count after the request.
//   One request is worked at a time. A refused request (full, empty, bad
//   position) goes from the check straight to its result. Otherwise the
//   entry memory is visited element by element (read issue, data use, loop
//   test); the single write / single read entry memory with registered read
//   sets this per-element order. The next request is taken in the cycle
//   after the result is loaded, even while that result still waits on the
//   receiver; a stalled receiver holds the block only when a second result
//   is ready.
//   Reset empties the store at once; entries are undefined until written.
module ordered_array_insert_delete_search #(
    parameter int CAPACITY  = oaids_pkg::CAPACITY_DEF,
    parameter int DATA_BITS = oaids_pkg::DATA_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic        [oaids_pkg::CMD_W-1:0]  i_command,
    input  logic        [oaids_pkg::POS_W-1:0]  i_position,
    input  logic signed [oaids_pkg::VAL_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [oaids_pkg::STAT_W-1:0] o_status,
    output logic                                o_found,
    output logic        [oaids_pkg::IDX_W-1:0]  o_index,
    output logic signed [oaids_pkg::VAL_W-1:0]  o_data_out,
    output logic        [oaids_pkg::CNT_W-1:0]  o_count
);

    oaids_pkg::t_dp_cmd  w_cmd;
    oaids_pkg::t_dp_stat w_stat;

    oaids_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    oaids_dp #(
        .CAPACITY  (CAPACITY),
        .DATA_BITS (DATA_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_command  (i_command),
        .i_position (i_position),
        .i_value    (i_value),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_status   (o_status),
        .o_found    (o_found),
        .o_index    (o_index),
        .o_data_out (o_data_out),
        .o_count    (o_count)
    );

endmodule
